>>> rtl/xrs_pkg.sv
// ----------------------------------------------------------------------------
// xrs_pkg
// Shared types and constants of the XY raster scan generator.
// ----------------------------------------------------------------------------
package xrs_pkg;

  // Scan geometry and pixel format
  localparam int unsigned X_PIXELS       = 128;
  localparam int unsigned Y_LINES        = 128;
  localparam int unsigned BITS_PER_PIXEL = 1;

  // Frame store
  localparam int unsigned STORE_DEPTH = 2048;
  localparam int unsigned ADDR_W      = 11;
  localparam int unsigned DATA_W      = 8;

  // Pixel slots within one byte
  localparam int unsigned SLOT_W = (BITS_PER_PIXEL == 2) ? 2 : 3;

  // Intensity map
  localparam logic [7:0] LEVEL_ON   = 8'd255;
  localparam logic [7:0] LEVEL_STEP = 8'd5;

  // Queue depths
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PTR_W = 2;
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = 2;

  // Request mode codes
  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef struct packed {
    logic       mode;
    logic [10:0] write_address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] x_level;
    logic [7:0] y_level;
    logic [7:0] z_level;
  } out_item_t;

  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic                 clearing;
    logic [RES_PTR_W:0]   res_count;
  } back_status_t;

endpackage

>>> rtl/xrs_ram.sv
// ----------------------------------------------------------------------------
// xrs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module xrs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/xrs_front.sv
// ----------------------------------------------------------------------------
// xrs_front
// Accepts requests, classifies them as tick or write, and queues them.
// ----------------------------------------------------------------------------
module xrs_front
  import xrs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_item_t in_i,
  output logic     full_o,
  input  logic     clearing_i,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o,
  input  logic     cmd_pop_i
);

  cmd_t                 slot_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMD_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMD_PTR_W:0]   count_q, count_d;
  logic                 do_push;
  logic                 do_pop;
  cmd_t                 new_cmd;

  assign full_o      = clearing_i || (count_q == (CMD_PTR_W+1)'(CMD_DEPTH));
  assign do_push     = push_i && !full_o;
  assign cmd_valid_o = (count_q != '0);
  assign do_pop      = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = slot_q[rd_ptr_q];

  always_comb begin
    new_cmd.op   = (in_i.mode == MODE_WRITE) ? OP_WRITE : OP_TICK;
    new_cmd.addr = in_i.write_address;
    new_cmd.data = in_i.write_data;
  end

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= new_cmd;
    end
  end

endmodule

>>> rtl/xrs_exec.sv
// ----------------------------------------------------------------------------
// xrs_exec
// Runs queued requests: clears the frame store after reset, stores bytes,
// and for each tick advances the scan counters, reads the current byte and
// maps the selected pixel to an intensity.
// ----------------------------------------------------------------------------
module xrs_exec
  import xrs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  cmd_t               cmd_i,
  output logic               cmd_pop_o,
  input  logic [RES_PTR_W:0] res_count_i,
  output logic               clearing_o,
  output logic               res_push_o,
  output out_item_t          res_o
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = '1;

  // Clearing pass
  logic              clr_q, clr_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;

  // Scan state
  logic [7:0]        col_q, col_d;
  logic [7:0]        row_q, row_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;

  // Read stage
  logic              s1_valid_q, s1_valid_d;
  logic [7:0]        s1_col_q;
  logic [7:0]        s1_row_q;
  logic [SLOT_W-1:0] s1_slot_q;

  logic              is_tick;
  logic              credit_ok;
  logic [8:0]        col_inc;
  logic [8:0]        row_inc;
  logic              wrap_col;
  logic              wrap_row;
  logic [7:0]        col_n;
  logic [7:0]        row_n;
  logic [ADDR_W-1:0] ptr_base;
  logic [SLOT_W-1:0] slot_n;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;

  logic [2:0]        slot3;
  logic [1:0]        pix2;
  logic [7:0]        z_level;

  assign clearing_o = clr_q;
  assign is_tick    = (cmd_i.op == OP_TICK);
  // A tick may issue only if its result has a seat in the result queue
  assign credit_ok  = ((RES_PTR_W+1)'(res_count_i) + (RES_PTR_W+1)'(s1_valid_q))
                      < (RES_PTR_W+1)'(RES_DEPTH);
  assign cmd_pop_o  = !clr_q && cmd_valid_i && (!is_tick || credit_ok);

  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == ADDR_W'(STORE_DEPTH - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  // Counter update for a tick
  always_comb begin
    col_inc  = {1'b0, col_q} + 9'd1;
    row_inc  = {1'b0, row_q} + 9'd1;
    wrap_col = (col_inc >= 9'(X_PIXELS));
    wrap_row = (row_inc >= 9'(Y_LINES));
    col_n    = wrap_col ? 8'd0 : col_inc[7:0];
    row_n    = row_q;
    ptr_base = ptr_q;
    if (wrap_col) begin
      row_n = wrap_row ? 8'd0 : row_inc[7:0];
      if (wrap_row) begin
        ptr_base = '0;
      end
    end
    slot_n = col_n[SLOT_W-1:0];
  end

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    ptr_d      = ptr_q;
    s1_valid_d = 1'b0;
    if (cmd_pop_o && is_tick) begin
      col_d      = col_n;
      row_d      = row_n;
      ptr_d      = (slot_n == LAST_SLOT) ? ptr_base + 1'b1 : ptr_base;
      s1_valid_d = 1'b1;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cmd_i.addr;
    ram_wdata = cmd_i.data;
    if (clr_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else if (cmd_pop_o && !is_tick) begin
      ram_we = 1'b1;
    end
  end

  xrs_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ptr_base),
    .rdata_o(ram_rdata)
  );

  // Pick the pixel, MSB first, and map it to an intensity
  always_comb begin
    slot3 = 3'(s1_slot_q);
    pix2  = 2'(ram_rdata >> (3'd6 - {slot3[1:0], 1'b0}));
    if (BITS_PER_PIXEL == 2) begin
      z_level = 8'({6'd0, pix2} * LEVEL_STEP);
    end else begin
      z_level = ram_rdata[3'd7 - slot3] ? LEVEL_ON : 8'd0;
    end
  end

  assign res_push_o    = s1_valid_q;
  assign res_o.x_level = s1_col_q;
  assign res_o.y_level = s1_row_q;
  assign res_o.z_level = z_level;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      col_q      <= '0;
      row_q      <= '0;
      ptr_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
      col_q      <= col_d;
      row_q      <= row_d;
      ptr_q      <= ptr_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_d) begin
      s1_col_q  <= col_n;
      s1_row_q  <= row_n;
      s1_slot_q <= slot_n;
    end
  end

endmodule

>>> rtl/xrs_res_queue.sv
// ----------------------------------------------------------------------------
// xrs_res_queue
// Holds finished results until the consumer pops them.
// ----------------------------------------------------------------------------
module xrs_res_queue
  import xrs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  out_item_t          res_i,
  output logic [RES_PTR_W:0] count_o,
  output logic               empty_o,
  input  logic               pop_i,
  output out_item_t          res_o
);

  out_item_t            entry_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [RES_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [RES_PTR_W:0]   count_q, count_d;
  logic                 do_pop;

  assign empty_o = (count_q == '0);
  assign do_pop  = pop_i && !empty_o;
  assign count_o = count_q;
  assign res_o   = entry_q[rd_ptr_q];

  // The executor only pushes when it holds a free seat
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

>>> rtl/xy_raster_scan_generator.sv
// Path: a tick goes through the command queue, the read stage and the result queue.
// Throughput: one request per cycle unless clearing or a full result queue stalls a tick.
// Write requests are stored in the frame store and give no result.
// Reset: counters and pointer go to zero; the frame store is then cleared one byte per
// cycle over all 2048 of its bytes, during which full stays high.
// ----------------------------------------------------------------------------
// xy_raster_scan_generator
// Raster scanner over a packed frame store producing X, Y and intensity levels.
// ----------------------------------------------------------------------------
module xy_raster_scan_generator
  import xrs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  input  in_item_t  in_i,
  output logic      full,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_o
);

  logic               cmd_valid;
  cmd_t               cmd;
  logic               cmd_pop;
  logic               res_push;
  out_item_t          res;
  back_status_t       back_status;
  logic               clearing;
  logic [RES_PTR_W:0] res_count;

  assign back_status.clearing  = clearing;
  assign back_status.res_count = res_count;

  xrs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_i       (in_i),
    .full_o     (full),
    .clearing_i (back_status.clearing),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  xrs_exec u_exec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .res_count_i(back_status.res_count),
    .clearing_o (clearing),
    .res_push_o (res_push),
    .res_o      (res)
  );

  xrs_res_queue u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .res_i  (res),
    .count_o(res_count),
    .empty_o(empty),
    .pop_i  (pop),
    .res_o  (out_o)
  );

endmodule
